// ===== rtl/svmmd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svmmd_pkg
// Shared types and constants for the SVM min-max duty calculator.
// ----------------------------------------------------------------------------
package svmmd_pkg;

  // Q15 format
  localparam int unsigned Q15_SHIFT = 15;
  localparam logic signed [15:0] SQRT3_HALF_Q15 = 16'sd28378;
  localparam logic signed [36:0] HALF_Q15 = 37'sd16384;

  // Internal widths
  localparam int unsigned VOLT_W  = 18;  // inverse Clarke phase voltage
  localparam int unsigned PHASE_W = 19;  // phase after zero-sequence removal
  localparam int unsigned RECIP_W = 31;
  localparam int unsigned DUTY_W  = 16;
  localparam int unsigned PROD_W  = PHASE_W + RECIP_W + 1;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_DUTY = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DUTY = 8'd1;
  localparam logic [DUTY_W-1:0] MIN_DUTY_RST = 16'd0;
  localparam logic [DUTY_W-1:0] MAX_DUTY_RST = 16'd32768;

  typedef struct packed {
    logic signed [15:0]        volt_alpha;
    logic signed [15:0]        volt_beta;
    logic        [RECIP_W-1:0] recip_bus;
  } svmmd_in_t;

  typedef struct packed {
    logic [DUTY_W-1:0] duty_u;
    logic [DUTY_W-1:0] duty_v;
    logic [DUTY_W-1:0] duty_w;
  } svmmd_out_t;

endpackage

// ===== rtl/svmmd_duty_scale.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svmmd_duty_scale
// One phase: scale by the bus reciprocal, add one half, clamp to the window.
// Two register stages: product, then clamped duty.
// ----------------------------------------------------------------------------
module svmmd_duty_scale
  import svmmd_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      prod_en_i,
  input  logic                      duty_en_i,
  input  logic signed [PHASE_W-1:0] phase_i,
  input  logic        [RECIP_W-1:0] recip_i,
  input  logic        [DUTY_W-1:0]  min_duty_i,
  input  logic        [DUTY_W-1:0]  max_duty_i,
  output logic        [DUTY_W-1:0]  duty_o
);

  logic signed [PROD_W-1:0] prod_d, prod_q;
  logic signed [PROD_W-Q15_SHIFT:0] sum;
  logic signed [PROD_W-Q15_SHIFT:0] lo, hi;
  logic [DUTY_W-1:0] duty_d, duty_q;

  assign prod_d = phase_i * $signed({1'b0, recip_i});

  // floor shift is the upper slice of the product
  assign sum = $signed({prod_q[PROD_W-1], prod_q[PROD_W-1:Q15_SHIFT]}) + HALF_Q15;
  assign lo  = $signed({{(PROD_W-Q15_SHIFT+1-DUTY_W){1'b0}}, min_duty_i});
  assign hi  = $signed({{(PROD_W-Q15_SHIFT+1-DUTY_W){1'b0}}, max_duty_i});

  always_comb begin
    if (sum < lo) begin
      duty_d = min_duty_i;
    end else if (sum > hi) begin
      duty_d = max_duty_i;
    end else begin
      duty_d = sum[DUTY_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (prod_en_i) begin
      prod_q <= prod_d;
    end
    if (duty_en_i) begin
      duty_q <= duty_d;
    end
  end

  assign duty_o = duty_q;

endmodule

// ===== rtl/svm_minmax_duty_calculator_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svm_minmax_duty_calculator_top
// SVM duty calculator with min-max zero-sequence injection.
// Each accepted input word passes through the stage registers in order, from
//   the beta product to the clamped duty register that drives the output.
// Throughput: one word per cycle while the output side takes words; each of the five stages holds one word.
// Reset: clears all stage valid bits, sets min_duty to 0 and max_duty to 32768.
// ----------------------------------------------------------------------------
module svm_minmax_duty_calculator_top
  import svmmd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // input words
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  svmmd_in_t             in_data_i,
  // result words
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output svmmd_out_t            out_data_o,
  // configuration writes
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned NSTG = 5;

  // Stage map:
  //   1  sqrt(3)/2 * beta product
  //   2  inverse Clarke phases u, v, w
  //   3  max/min midpoint removed from each phase
  //   4  phase * reciprocal (in svmmd_duty_scale)
  //   5  shift, add half, clamp (in svmmd_duty_scale); this is the output reg

  logic [NSTG:1] vld_q, vld_d;
  logic [NSTG:1] rdy;
  logic [NSTG:1] load;

  logic [DUTY_W-1:0] min_duty_q, max_duty_q;

  // ---------------------------------------------------------------------------
  // Configuration registers. Always ready; ignore indexes past the list.
  // ---------------------------------------------------------------------------
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_duty_q <= MIN_DUTY_RST;
      max_duty_q <= MAX_DUTY_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_MIN_DUTY: min_duty_q <= cfg_data_i;
        REG_MAX_DUTY: max_duty_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline control: a stage advances when it is empty or the stage after it
  // advances. Only a full pipeline with a held output word stalls the input.
  // ---------------------------------------------------------------------------
  always_comb begin
    rdy[NSTG] = !vld_q[NSTG] || out_ready_i;
    for (int k = NSTG - 1; k >= 1; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  always_comb begin
    vld_d   = vld_q;
    load[1] = rdy[1] && in_valid_i;
    if (rdy[1]) begin
      vld_d[1] = in_valid_i;
    end
    for (int k = 2; k <= NSTG; k++) begin
      load[k] = rdy[k] && vld_q[k-1];
      if (rdy[k]) begin
        vld_d[k] = vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_ready_o  = rdy[1];
  assign out_valid_o = vld_q[NSTG];

  // ---------------------------------------------------------------------------
  // Stage 1: beta product. Hold alpha and the reciprocal alongside.
  // ---------------------------------------------------------------------------
  logic signed [31:0]        s1_prod_d, s1_prod_q;
  logic signed [15:0]        s1_alpha_q;
  logic        [RECIP_W-1:0] s1_recip_q;

  assign s1_prod_d = SQRT3_HALF_Q15 * $signed(in_data_i.volt_beta);

  always_ff @(posedge clk_i) begin
    if (load[1]) begin
      s1_prod_q  <= s1_prod_d;
      s1_alpha_q <= in_data_i.volt_alpha;
      s1_recip_q <= in_data_i.recip_bus;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: inverse Clarke. Both shifts floor, so they are plain slices.
  // ---------------------------------------------------------------------------
  logic signed [VOLT_W-1:0]  beta_scaled, half_a;
  logic signed [VOLT_W-1:0]  s2_vu_d, s2_vv_d, s2_vw_d;
  logic signed [VOLT_W-1:0]  s2_vu_q, s2_vv_q, s2_vw_q;
  logic        [RECIP_W-1:0] s2_recip_q;

  assign beta_scaled = $signed({s1_prod_q[31], s1_prod_q[31:Q15_SHIFT]});
  assign half_a      = $signed({{3{s1_alpha_q[15]}}, s1_alpha_q[15:1]});
  assign s2_vu_d     = $signed({{2{s1_alpha_q[15]}}, s1_alpha_q});
  assign s2_vv_d     = beta_scaled - half_a;
  assign s2_vw_d     = -half_a - beta_scaled;

  always_ff @(posedge clk_i) begin
    if (load[2]) begin
      s2_vu_q    <= s2_vu_d;
      s2_vv_q    <= s2_vv_d;
      s2_vw_q    <= s2_vw_d;
      s2_recip_q <= s1_recip_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: min-max injection. Drop the midpoint of max and min.
  // ---------------------------------------------------------------------------
  logic signed [VOLT_W-1:0]  vmax, vmin, common;
  logic signed [VOLT_W:0]    mid_sum;
  logic signed [PHASE_W-1:0] s3_pu_d, s3_pv_d, s3_pw_d;
  logic signed [PHASE_W-1:0] s3_pu_q, s3_pv_q, s3_pw_q;
  logic        [RECIP_W-1:0] s3_recip_q;

  always_comb begin
    vmax = s2_vu_q;
    vmin = s2_vu_q;
    if (s2_vv_q > vmax) vmax = s2_vv_q;
    if (s2_vw_q > vmax) vmax = s2_vw_q;
    if (s2_vv_q < vmin) vmin = s2_vv_q;
    if (s2_vw_q < vmin) vmin = s2_vw_q;
  end

  assign mid_sum = $signed({vmax[VOLT_W-1], vmax}) + $signed({vmin[VOLT_W-1], vmin});
  assign common  = mid_sum[VOLT_W:1];

  assign s3_pu_d = $signed({s2_vu_q[VOLT_W-1], s2_vu_q}) - $signed({common[VOLT_W-1], common});
  assign s3_pv_d = $signed({s2_vv_q[VOLT_W-1], s2_vv_q}) - $signed({common[VOLT_W-1], common});
  assign s3_pw_d = $signed({s2_vw_q[VOLT_W-1], s2_vw_q}) - $signed({common[VOLT_W-1], common});

  always_ff @(posedge clk_i) begin
    if (load[3]) begin
      s3_pu_q    <= s3_pu_d;
      s3_pv_q    <= s3_pv_d;
      s3_pw_q    <= s3_pw_d;
      s3_recip_q <= s2_recip_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stages 4 and 5: scale and clamp, one lane per phase.
  // ---------------------------------------------------------------------------
  svmmd_duty_scale u_scale_u (
    .clk_i      (clk_i),
    .prod_en_i  (load[4]),
    .duty_en_i  (load[5]),
    .phase_i    (s3_pu_q),
    .recip_i    (s3_recip_q),
    .min_duty_i (min_duty_q),
    .max_duty_i (max_duty_q),
    .duty_o     (out_data_o.duty_u)
  );

  svmmd_duty_scale u_scale_v (
    .clk_i      (clk_i),
    .prod_en_i  (load[4]),
    .duty_en_i  (load[5]),
    .phase_i    (s3_pv_q),
    .recip_i    (s3_recip_q),
    .min_duty_i (min_duty_q),
    .max_duty_i (max_duty_q),
    .duty_o     (out_data_o.duty_v)
  );

  svmmd_duty_scale u_scale_w (
    .clk_i      (clk_i),
    .prod_en_i  (load[4]),
    .duty_en_i  (load[5]),
    .phase_i    (s3_pw_q),
    .recip_i    (s3_recip_q),
    .min_duty_i (min_duty_q),
    .max_duty_i (max_duty_q),
    .duty_o     (out_data_o.duty_w)
  );

endmodule

// ===== rtl/svmmd_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svmmd_checker
// Port-level checks for the SVM duty calculator, bound to the top level.
// ----------------------------------------------------------------------------
module svmmd_checker
  import svmmd_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_o,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input svmmd_out_t            out_data_o,
  input logic                  cfg_valid_i,
  input logic                  cfg_ready_o
);

  // a held output word stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output word changed while stalled");

  // input backpressure only while an output word is held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output backpressure");

  // with the output always taken meanwhile, an accepted word must show up as an output word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni, 5) && $past(in_valid_i && in_ready_o, 5) &&
    $past(out_ready_i, 1) && $past(out_ready_i, 2) && $past(out_ready_i, 3) &&
    $past(out_ready_i, 4) && $past(out_ready_i, 5) |-> out_valid_o)
    else $error("output word missing after pipeline latency");

  // configuration writes never stall
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("configuration write stalled");

endmodule

bind svm_minmax_duty_calculator_top svmmd_checker u_svmmd_checker (.*);

// ===== test/duty_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// duty_checker
// Watches the command, result and register channels of the SVM duty
// calculator and predicts the three phase duties of every accepted command
// word. Result words are compared in arrival order against those predictions.
// ----------------------------------------------------------------------------
module duty_checker
  import svmmd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  svmmd_in_t             in_data_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  svmmd_out_t            out_data_i,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int unsigned           waiting_o,
  output int unsigned           checked_o,
  output int unsigned           errors_o
);

  localparam longint SQRT3_HALF = 28378;
  localparam longint HALF_DUTY  = 16384;

  logic [DUTY_W-1:0] duty_floor;
  logic [DUTY_W-1:0] duty_ceil;
  svmmd_out_t        expected_duties [$];
  svmmd_out_t        want;
  int unsigned       bad;

  // Scale one phase by the bus reciprocal, center on one half and clamp.
  // A value under the floor takes the floor even when the window is inverted.
  function automatic logic [DUTY_W-1:0] scale_phase(input longint phase,
                                                    input longint recip,
                                                    input logic [DUTY_W-1:0] lo,
                                                    input logic [DUTY_W-1:0] hi);
    longint d;
    d = HALF_DUTY + ((phase * recip) >>> Q15_SHIFT);
    if (d < longint'(lo)) d = longint'(lo);
    else if (d > longint'(hi)) d = longint'(hi);
    return d[DUTY_W-1:0];
  endfunction

  function automatic svmmd_out_t predict_duties(input svmmd_in_t w,
                                                input logic [DUTY_W-1:0] lo,
                                                input logic [DUTY_W-1:0] hi);
    longint va, vb, recip, beta_scaled, half_a, vu, vv, vw, vmax, vmin, common;
    svmmd_out_t r;
    va          = longint'($signed(w.volt_alpha));
    vb          = longint'($signed(w.volt_beta));
    recip       = longint'(w.recip_bus);
    beta_scaled = (SQRT3_HALF * vb) >>> Q15_SHIFT;
    half_a      = va >>> 1;
    vu          = va;
    vv          = beta_scaled - half_a;
    vw          = -half_a - beta_scaled;
    vmax        = vu;
    vmin        = vu;
    if (vv > vmax) vmax = vv;
    if (vw > vmax) vmax = vw;
    if (vv < vmin) vmin = vv;
    if (vw < vmin) vmin = vw;
    common      = (vmax + vmin) >>> 1;
    r.duty_u    = scale_phase(vu - common, recip, lo, hi);
    r.duty_v    = scale_phase(vv - common, recip, lo, hi);
    r.duty_w    = scale_phase(vw - common, recip, lo, hi);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      duty_floor <= MIN_DUTY_RST;
      duty_ceil  <= MAX_DUTY_RST;
      expected_duties.delete();
      waiting_o  <= 0;
      checked_o  <= 0;
      errors_o   <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_MIN_DUTY: duty_floor <= cfg_data_i;
          REG_MAX_DUTY: duty_ceil  <= cfg_data_i;
          default: ;
        endcase
      end
      bad = 0;
      if (out_valid_i && out_ready_i) begin
        if (expected_duties.size() == 0) begin
          $error("result word %h arrived with no command pending", out_data_i);
          bad++;
        end else begin
          want = expected_duties.pop_front();
          if (out_data_i.duty_u !== want.duty_u) begin
            $error("duty_u: expected %0d, got %0d", want.duty_u, out_data_i.duty_u);
            bad++;
          end
          if (out_data_i.duty_v !== want.duty_v) begin
            $error("duty_v: expected %0d, got %0d", want.duty_v, out_data_i.duty_v);
            bad++;
          end
          if (out_data_i.duty_w !== want.duty_w) begin
            $error("duty_w: expected %0d, got %0d", want.duty_w, out_data_i.duty_w);
            bad++;
          end
        end
        checked_o <= checked_o + 1;
      end
      if (in_valid_i && in_ready_i) begin
        expected_duties.push_back(predict_duties(in_data_i, duty_floor, duty_ceil));
      end
      waiting_o <= expected_duties.size();
      errors_o  <= errors_o + bad;
    end
  end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives alpha/beta commands and bus reciprocals into the SVM duty calculator
// under a series of duty windows, with random idling on both channels. A
// separate checker predicts each duty triple; this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench
  import svmmd_pkg::*;
();

  localparam int RAND_PER_WINDOW = 108;   // random words per duty window
  localparam int NUM_WINDOWS     = 6;     // windows written after reset
  localparam int IDLE_PCT        = 12;    // chance of an idle cycle, percent
  localparam int DRAIN_CYCLES    = 12;    // idle wait after the final drain
  localparam int LIMIT_CYCLES    = 200000;

  localparam logic [RECIP_W-1:0]   RECIP_MAX        = '1;
  localparam logic [RECIP_W-1:0]   RECIP_UNITY      = 31'd32768;
  localparam logic [DUTY_W-1:0]    DUTY_FULL        = 16'd32768;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_UNUSED = REG_MAX_DUTY + 8'd1;

  logic                  clk_i;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  svmmd_in_t             in_data_i   = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  svmmd_out_t            out_data_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;

  logic        steady = 1'b0;   // high: neither side idles
  int unsigned waiting;
  int unsigned checked;
  int unsigned errors;
  int unsigned words_sent = 0;

  svm_minmax_duty_calculator_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  duty_checker checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_i  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_i (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .waiting_o   (waiting),
    .checked_o   (checked),
    .errors_o    (errors)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Result side: stall at random, except during the steady stretch.
  always @(posedge clk_i) begin
    out_ready_i <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  function automatic svmmd_in_t command_word(input int alpha, input int beta,
                                             input logic [RECIP_W-1:0] recip);
    svmmd_in_t w;
    w.volt_alpha = 16'(alpha);
    w.volt_beta  = 16'(beta);
    w.recip_bus  = recip;
    return w;
  endfunction

  // Pick one of the voltage corners, including -1 for the floor shifts.
  function automatic logic [15:0] corner_volt();
    case ($urandom_range(3))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'hffff;
      default: return 16'h0000;
    endcase
  endfunction

  // Mostly realistic commands with the reciprocal near unity, so duties land
  // inside the window; the rest are small signals, wild reciprocals and corners.
  function automatic svmmd_in_t make_word();
    svmmd_in_t   w;
    int unsigned mode;
    mode = $urandom_range(99);
    w.volt_alpha = 16'($urandom());
    w.volt_beta  = 16'($urandom());
    if (mode < 60) begin
      w.recip_bus = 31'($urandom_range(70000, 20000));
    end else if (mode < 75) begin
      w.volt_alpha = 16'(int'($urandom_range(8191, 0)) - 4096);
      w.volt_beta  = 16'(int'($urandom_range(8191, 0)) - 4096);
      w.recip_bus  = 31'($urandom_range(32'h000f_ffff, 0));
    end else if (mode < 90) begin
      w.recip_bus = 31'($urandom_range(32'h7fff_ffff, 0));
    end else begin
      w.volt_alpha = corner_volt();
      w.volt_beta  = corner_volt();
      case ($urandom_range(2))
        0:       w.recip_bus = '0;
        1:       w.recip_bus = RECIP_MAX;
        default: w.recip_bus = 31'd1;
      endcase
    end
    return w;
  endfunction

  // Offer one word; valid stays high afterwards so back-to-back words need
  // no extra assignment. Idle cycles lower it first.
  task automatic send_word(input svmmd_in_t w);
    if (!steady) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    words_sent++;
  endtask

  // Drop valid and hold until the checker has nothing outstanding.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (waiting != 0);
  endtask

  // Leaves cfg_valid_i high; the caller lowers it after its last write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // Write both limits, then a junk write to an unused index that must be
  // dropped by the block.
  task automatic set_window(input logic [DUTY_W-1:0] lo, input logic [DUTY_W-1:0] hi);
    write_reg(REG_MIN_DUTY, lo);
    write_reg(REG_MAX_DUTY, hi);
    write_reg(8'($urandom_range(255, REG_FIRST_UNUSED)), 16'($urandom()));
    cfg_valid_i <= 1'b0;
  endtask

  initial begin : stimulus
    logic [DUTY_W-1:0] lo;
    logic [DUTY_W-1:0] hi;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed words under the reset window: axis extremes, all four corners
    // with full-scale reciprocals, zero reciprocals, -1 and +1 for the floor
    // shifts, and huge ratios that must saturate instead of wrapping.
    send_word(command_word(0, 0, RECIP_UNITY));
    send_word(command_word(32767, 0, RECIP_UNITY));
    send_word(command_word(-32768, 0, RECIP_UNITY));
    send_word(command_word(0, 32767, RECIP_UNITY));
    send_word(command_word(0, -32768, RECIP_UNITY));
    send_word(command_word(32767, 32767, RECIP_MAX));
    send_word(command_word(-32768, -32768, RECIP_MAX));
    send_word(command_word(32767, -32768, RECIP_MAX));
    send_word(command_word(-32768, 32767, RECIP_MAX));
    send_word(command_word(-1, -1, RECIP_UNITY));
    send_word(command_word(1, 1, RECIP_UNITY));
    send_word(command_word(-1, 1, 31'd1));
    send_word(command_word(12345, -23456, '0));
    send_word(command_word(32767, 32767, '0));
    send_word(command_word(-3, -5, 31'd65536));
    send_word(command_word(20000, -10000, 31'd46341));
    send_word(command_word(-32768, -32768, 31'd1));
    send_word(command_word(16384, 28378, RECIP_UNITY));
    send_word(command_word(100, -100, RECIP_MAX));

    // Let the pipeline run completely dry once before random traffic.
    wait_drained();

    for (int win = 0; win <= NUM_WINDOWS; win++) begin
      if (win > 0) begin
        case (win)
          1: begin lo = 16'd1638;  hi = 16'd31130; end  // 5..95 percent
          2: begin lo = '0;        hi = '0;        end  // zero-width at bottom
          3: begin lo = DUTY_FULL; hi = DUTY_FULL; end  // zero-width at top
          4: begin lo = 16'd20000; hi = 16'd12000; end  // inverted window
          5: begin
            lo = 16'($urandom_range(DUTY_FULL, 0));
            hi = 16'($urandom_range(DUTY_FULL, 0));
          end
          default: begin lo = '0; hi = DUTY_FULL; end   // full range again
        endcase
        wait_drained();
        set_window(lo, hi);
      end
      // The last window runs with no idling on either side.
      steady <= (win == NUM_WINDOWS);
      for (int n = 0; n < RAND_PER_WINDOW; n++) begin
        send_word(make_word());
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d command words and checked %0d duty triples across %0d windows,",
             words_sent, checked, NUM_WINDOWS + 1);
    $display("including zero-width, full-scale and inverted duty limits.");
    if (errors == 0) begin
      $display("[svm_minmax_duty_calculator_top] OK");
    end else begin
      $display("[svm_minmax_duty_calculator_top] ERROR");
    end
    $finish;
  end

  // Hard stop if a handshake never completes.
  initial begin : watchdog
    repeat (LIMIT_CYCLES) @(posedge clk_i);
    $display("timeout after %0d cycles, %0d results outstanding", LIMIT_CYCLES, waiting);
    $display("[svm_minmax_duty_calculator_top] ERROR");
    $finish;
  end

endmodule
